### hdl/dfs_edge_classifier_defines.svh
// Assertion macros for the depth-first search edge classifier.
// Used by the top level only; depends on nothing else.
`ifndef DFS_EDGE_CLASSIFIER_DEFINES_SVH
`define DFS_EDGE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DFS_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("dfs_edge_classifier: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define DFS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("dfs_edge_classifier: next-cycle check failed");

`endif

### hdl/dfs_pkg.sv
// Shared types and constants for the depth-first search edge classifier.
// No dependencies; imported by every module of the block except dfs_ram.
`default_nettype none

package dfs_pkg;

    localparam int MAX_NODES = 16;
    localparam int MAX_EDGES = 32;
    localparam int NODE_W    = 4;
    localparam int EDGE_W    = 5;
    localparam int CNT_W     = 6;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_RUN   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GRAY  = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    localparam logic [2:0] ECLASS_NONE    = 3'd0;
    localparam logic [2:0] ECLASS_TREE    = 3'd1;
    localparam logic [2:0] ECLASS_BACK    = 3'd2;
    localparam logic [2:0] ECLASS_FORWARD = 3'd3;
    localparam logic [2:0] ECLASS_CROSS   = 3'd4;

    localparam logic KIND_NODE = 1'b0;
    localparam logic KIND_EDGE = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] src;
        logic [3:0] dst;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [4:0] index;
        logic [5:0] discovery;
        logic [5:0] finish;
        logic [3:0] predecessor;
        logic       has_predecessor;
        logic [2:0] edge_type;
        logic [5:0] cycle_count;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic idle;
        logic init;
        logic root_next;
        logic push_root;
        logic scan_load;
        logic scan_next;
        logic pop;
        logic take;
        logic match_sel;
        logic match_next;
        logic classify;
        logic emit_init;
        logic emit_step;
    } cmd_t;

    typedef struct packed {
        logic root_done;
        logic root_white;
        logic stack_empty;
        logic scan_end;
        logic scan_hit;
        logic match_hit;
        logic emit_none;
        logic emit_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/dfs_edge_classifier.sv
// Top level of the depth-first search edge classifier.
// Depends on dfs_pkg, dfs_ctrl, dfs_datapath and the assertion macro header.
`default_nettype none
`include "dfs_edge_classifier_defines.svh"

// Directed edges are loaded into a 32-entry table one item per cycle while
// no run is in progress; an edge naming a node at or above node_count, or
// arriving with the table full, is dropped. A clear item empties the table.
// A run item searches depth first from each still-white node in index order,
// walking each node's edges in load order, then emits one record per node
// followed by one per loaded edge, the final record flagged with last. Loads
// and clears never raise in_stall. A run holds in_stall high until its last
// record has been handed to the output register; its length is set by the
// single read port of the edge table: each edge-scan step reads one entry
// through S_SCAN_A and S_SCAN_B and, for each edge taken, the table is read
// again from entry 0 through S_MATCH_A and S_MATCH_B to find the first copy
// of that edge. Each node's scan walks the whole table once, and records
// leave one per cycle while the output is not stalled. The output register
// lets a new item be accepted while the last record still waits.
// node_count is written through cfg_valid/cfg_data (cfg_ready is always high)
// and must only be written while the block is idle.

module dfs_edge_classifier
    import dfs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_item,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;
    logic in_fire;
    logic run_fire;
    logic edge_rec;
    logic edge_no_times;

    // Take items only while the sequencer is idle
    assign in_stall  = !cmd.idle;
    assign in_fire   = in_valid && !in_stall;
    assign run_fire  = in_fire && (in_item.func == FUNC_RUN);
    assign cfg_ready = 1'b1;

    dfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_start (run_fire),
        .sts       (sts),
        .cmd       (cmd)
    );

    dfs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_fire   (in_fire),
        .in_item   (in_item),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign edge_rec      = out_valid && (out_item.kind == KIND_EDGE);
    assign edge_no_times = (out_item.discovery == 6'd0) && (out_item.finish == 6'd0);

    // A run item must leave the block busy on the next cycle
    `DFS_ASSERT_NEXT(a_run_busy, clk, rst_n, run_fire, in_stall)
    // Edge records carry no node times
    `DFS_ASSERT_NOW(a_edge_times, clk, rst_n, edge_rec, edge_no_times)
    // The search stack is empty whenever items are taken
    `DFS_ASSERT_NOW(a_idle_stack, clk, rst_n, !in_stall, sts.stack_empty)

endmodule

`default_nettype wire

### hdl/dfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/dfs_ctrl.sv
// Sequencer for the search, the edge scans and the record emission.
// Depends on dfs_pkg for the command and status structs.
`default_nettype none

module dfs_ctrl
    import dfs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     run_start,
    input  wire sts_t     sts,
    output cmd_t          cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INIT    = 9'b000000010,
        S_ROOT    = 9'b000000100,
        S_TOP     = 9'b000001000,
        S_SCAN_A  = 9'b000010000,
        S_SCAN_B  = 9'b000100000,
        S_MATCH_A = 9'b001000000,
        S_MATCH_B = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (run_start)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (sts.root_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = sts.emit_none ? S_IDLE : S_EMIT;
                end
                else if (sts.root_white)
                begin
                    cmd.push_root = 1'b1;
                    state_next    = S_TOP;
                end
                else
                begin
                    cmd.root_next = 1'b1;
                end
            end
            S_TOP:
            begin
                if (sts.stack_empty)
                begin
                    cmd.root_next = 1'b1;
                    state_next    = S_ROOT;
                end
                else
                begin
                    cmd.scan_load = 1'b1;
                    state_next    = S_SCAN_A;
                end
            end
            S_SCAN_A:
            begin
                if (sts.scan_end)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_TOP;
                end
                else
                begin
                    state_next = S_SCAN_B;
                end
            end
            S_SCAN_B:
            begin
                if (sts.scan_hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_MATCH_A;
                end
                else
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_A;
                end
            end
            S_MATCH_A:
            begin
                cmd.match_sel = 1'b1;
                state_next    = S_MATCH_B;
            end
            S_MATCH_B:
            begin
                if (sts.match_hit)
                begin
                    cmd.classify = 1'b1;
                    state_next   = S_TOP;
                end
                else
                begin
                    cmd.match_next = 1'b1;
                    state_next     = S_MATCH_A;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_step = 1'b1;
                    if (sts.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/dfs_datapath.sv
// Edge table, node tables, search stack, counters and output register.
// Depends on dfs_pkg and dfs_ram.
`default_nettype none

module dfs_datapath
    import dfs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cmd_t      cmd,
    input  wire logic      in_fire,
    input  wire in_item_t  in_item,
    input  wire logic      cfg_write,
    input  wire logic [4:0] cfg_data,
    input  wire logic      out_stall,
    output sts_t           sts,
    output logic           out_valid,
    output out_item_t      out_item
);

    logic [4:0] node_count_reg;
    logic [5:0] edges_loaded_reg;
    logic [2:0] eclass_reg [MAX_EDGES];
    logic [1:0] color_reg  [MAX_NODES];
    logic [5:0] disc_reg   [MAX_NODES];
    logic [5:0] fin_reg    [MAX_NODES];
    logic [3:0] par_reg    [MAX_NODES];
    logic       pv_reg     [MAX_NODES];
    logic [3:0] stk_node_reg [MAX_NODES];
    logic [5:0] stk_cur_reg  [MAX_NODES];
    logic [5:0] stk_disc_reg [MAX_NODES];
    logic [4:0] depth_reg;
    logic [5:0] clk_cnt_reg;
    logic [5:0] back_reg;
    logic [4:0] root_reg;
    logic [5:0] scan_reg;
    logic [5:0] match_reg;
    logic [3:0] v_reg;
    logic [5:0] emit_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic [4:0] n_act;
    logic [4:0] depth_m1;
    logic [3:0] top;
    logic [4:0] push_idx;
    logic [3:0] u;
    logic       load_ok;
    logic [4:0] rd_addr;
    logic [7:0] rd_data;
    logic [3:0] rd_src;
    logic [3:0] rd_dst;
    logic [5:0] total;
    logic [5:0] clk_inc;
    logic [5:0] edge_off;
    out_item_t  rec;

    assign n_act    = (node_count_reg > 5'(MAX_NODES)) ? 5'(MAX_NODES) : node_count_reg;
    assign depth_m1 = depth_reg - 5'd1;
    assign top      = depth_m1[3:0];
    assign push_idx = depth_reg;
    assign u        = stk_node_reg[top];
    assign clk_inc  = clk_cnt_reg + 6'd1;
    assign total    = {1'b0, n_act} + edges_loaded_reg;
    assign edge_off = emit_reg - {1'b0, n_act};
    assign rd_src   = rd_data[7:4];
    assign rd_dst   = rd_data[3:0];
    assign rd_addr  = cmd.match_sel ? match_reg[4:0] : scan_reg[4:0];

    assign load_ok = in_fire && (in_item.func == FUNC_LOAD)
                     && ({1'b0, in_item.src} < n_act) && ({1'b0, in_item.dst} < n_act)
                     && (edges_loaded_reg < 6'(MAX_EDGES));

    dfs_ram #(
        .WIDTH (8),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (load_ok),
        .wr_addr (edges_loaded_reg[4:0]),
        .wr_data ({in_item.src, in_item.dst}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        sts.root_done   = root_reg >= n_act;
        sts.root_white  = color_reg[root_reg[3:0]] == COLOR_WHITE;
        sts.stack_empty = depth_reg == 5'd0;
        sts.scan_end    = scan_reg >= edges_loaded_reg;
        sts.scan_hit    = (rd_src == u) && ({1'b0, rd_dst} < n_act);
        sts.match_hit   = (rd_src == u) && (rd_dst == v_reg);
        sts.emit_none   = total == 6'd0;
        sts.emit_last   = (emit_reg + 6'd1) == total;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // Build the record for the current emit position
    always_comb
    begin
        rec             = '0;
        rec.cycle_count = back_reg;
        rec.last        = sts.emit_last;
        if (emit_reg < {1'b0, n_act})
        begin
            rec.kind            = KIND_NODE;
            rec.index           = emit_reg[4:0];
            rec.discovery       = disc_reg[emit_reg[3:0]];
            rec.finish          = fin_reg[emit_reg[3:0]];
            rec.has_predecessor = pv_reg[emit_reg[3:0]];
            rec.predecessor     = pv_reg[emit_reg[3:0]] ? par_reg[emit_reg[3:0]] : 4'd0;
        end
        else
        begin
            rec.kind      = KIND_EDGE;
            rec.index     = edge_off[4:0];
            rec.edge_type = eclass_reg[edge_off[4:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg   <= 5'(MAX_NODES);
            edges_loaded_reg <= '0;
            depth_reg        <= '0;
            clk_cnt_reg      <= '0;
            back_reg         <= '0;
            root_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int k = 0; k < MAX_EDGES; k++)
            begin
                eclass_reg[k] <= ECLASS_NONE;
            end
            for (int k = 0; k < MAX_NODES; k++)
            begin
                color_reg[k] <= COLOR_WHITE;
                disc_reg[k]  <= '0;
                fin_reg[k]   <= '0;
                par_reg[k]   <= '0;
                pv_reg[k]    <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                node_count_reg <= cfg_data;
            end
            if (load_ok)
            begin
                edges_loaded_reg <= edges_loaded_reg + 6'd1;
            end
            if (in_fire && (in_item.func == FUNC_CLEAR))
            begin
                edges_loaded_reg <= '0;
            end
            if (cmd.init)
            begin
                depth_reg   <= '0;
                clk_cnt_reg <= '0;
                back_reg    <= '0;
                root_reg    <= '0;
                for (int k = 0; k < MAX_EDGES; k++)
                begin
                    eclass_reg[k] <= ECLASS_NONE;
                end
                for (int k = 0; k < MAX_NODES; k++)
                begin
                    color_reg[k] <= COLOR_WHITE;
                    par_reg[k]   <= '0;
                    pv_reg[k]    <= 1'b0;
                end
            end
            if (cmd.root_next)
            begin
                root_reg <= root_reg + 5'd1;
            end
            if (cmd.push_root)
            begin
                color_reg[root_reg[3:0]] <= COLOR_GRAY;
                disc_reg[root_reg[3:0]]  <= clk_inc;
                clk_cnt_reg              <= clk_inc;
                depth_reg                <= depth_reg + 5'd1;
            end
            if (cmd.pop)
            begin
                color_reg[u] <= COLOR_BLACK;
                fin_reg[u]   <= clk_inc;
                clk_cnt_reg  <= clk_inc;
                depth_reg    <= depth_m1;
            end
            if (cmd.classify)
            begin
                case (color_reg[v_reg])
                    COLOR_WHITE:
                    begin
                        eclass_reg[match_reg[4:0]] <= ECLASS_TREE;
                        par_reg[v_reg]   <= u;
                        pv_reg[v_reg]    <= 1'b1;
                        color_reg[v_reg] <= COLOR_GRAY;
                        disc_reg[v_reg]  <= clk_inc;
                        clk_cnt_reg      <= clk_inc;
                        depth_reg        <= depth_reg + 5'd1;
                    end
                    COLOR_GRAY:
                    begin
                        eclass_reg[match_reg[4:0]] <= ECLASS_BACK;
                        back_reg <= back_reg + 6'd1;
                    end
                    default:
                    begin
                        if (stk_disc_reg[top] < disc_reg[v_reg])
                        begin
                            eclass_reg[match_reg[4:0]] <= ECLASS_FORWARD;
                        end
                        else if (stk_disc_reg[top] > disc_reg[v_reg])
                        begin
                            eclass_reg[match_reg[4:0]] <= ECLASS_CROSS;
                        end
                    end
                endcase
            end
            if (cmd.emit_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stack frames, scan pointers and output payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.push_root)
        begin
            stk_node_reg[push_idx[3:0]] <= root_reg[3:0];
            stk_cur_reg[push_idx[3:0]]  <= '0;
            stk_disc_reg[push_idx[3:0]] <= clk_inc;
        end
        if (cmd.classify && (color_reg[v_reg] == COLOR_WHITE))
        begin
            stk_node_reg[push_idx[3:0]] <= v_reg;
            stk_cur_reg[push_idx[3:0]]  <= '0;
            stk_disc_reg[push_idx[3:0]] <= clk_inc;
        end
        if (cmd.scan_load)
        begin
            scan_reg <= stk_cur_reg[top];
        end
        if (cmd.scan_next)
        begin
            scan_reg <= scan_reg + 6'd1;
        end
        if (cmd.take)
        begin
            stk_cur_reg[top] <= scan_reg + 6'd1;
            v_reg            <= rd_dst;
            match_reg        <= '0;
        end
        if (cmd.match_next)
        begin
            match_reg <= match_reg + 6'd1;
        end
        if (cmd.emit_init)
        begin
            emit_reg <= '0;
        end
        if (cmd.emit_step)
        begin
            out_reg  <= rec;
            emit_reg <= emit_reg + 6'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

### dv/tb_dfs_edge_classifier.sv
// Self-checking testbench for the depth-first search edge classifier.
// Depends on dfs_pkg and the dfs_edge_classifier RTL; reads no files.
`default_nettype none

module tb_dfs_edge_classifier;
    import dfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Table depth, node limit, unused func code and settle time used by the bench
    localparam int TABLE_DEPTH = MAX_EDGES;
    localparam int NODE_LIMIT  = MAX_NODES;
    localparam int FUNC_UNUSED = 3;
    localparam int SETTLE      = 40;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [4:0] cfg_data;

    dfs_edge_classifier DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predictor state: a private copy of the edge table and search state
    logic [3:0] tbl_src [TABLE_DEPTH];
    logic [3:0] tbl_dst [TABLE_DEPTH];
    int         tbl_fill;
    logic [2:0] tbl_class [TABLE_DEPTH];
    logic [1:0] colour [NODE_LIMIT];
    logic [5:0] disc_at [NODE_LIMIT];
    logic [5:0] fin_at [NODE_LIMIT];
    logic [3:0] parent_of [NODE_LIMIT];
    logic       has_parent [NODE_LIMIT];
    int         stk_node [NODE_LIMIT];
    int         stk_cursor [NODE_LIMIT];
    int         stk_depth;
    logic [5:0] tick;
    logic [5:0] back_total;
    logic [4:0] nodes_cfg;

    out_item_t  pending_records[$];

    int failures;
    int records_seen;
    int runs_sent;
    int loads_sent;
    int burst_left;

    // Clock: 4 ns period
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit on the whole run
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // Push a node onto the search stack and stamp its discovery time
    function automatic void discover(int v);
        if (stk_depth >= NODE_LIMIT)
            return;
        colour[v] = COLOR_GRAY;
        tick = tick + 6'd1;
        disc_at[v] = tick;
        stk_node[stk_depth] = v;
        stk_cursor[stk_depth] = 0;
        stk_depth++;
    endfunction

    // Table position of the first copy of edge u->v
    function automatic int first_copy(int u, int v);
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_src[i] == u && tbl_dst[i] == v)
                return i;
        return 0;
    endfunction

    function automatic void depth_first(int n);
        int top;
        int u;
        int i;
        int v;
        int e;
        for (int root = 0; root < n; root++)
        begin
            if (colour[root] != COLOR_WHITE)
                continue;
            discover(root);
            while (stk_depth > 0)
            begin
                top = stk_depth - 1;
                u = stk_node[top];
                i = stk_cursor[top];
                while (i < tbl_fill && !(tbl_src[i] == u && tbl_dst[i] < n))
                    i++;
                if (i >= tbl_fill)
                begin
                    colour[u] = COLOR_BLACK;
                    tick = tick + 6'd1;
                    fin_at[u] = tick;
                    stk_depth--;
                    continue;
                end
                stk_cursor[top] = i + 1;
                v = tbl_dst[i];
                e = first_copy(u, v);
                if (colour[v] == COLOR_WHITE)
                begin
                    tbl_class[e] = ECLASS_TREE;
                    parent_of[v] = u[3:0];
                    has_parent[v] = 1'b1;
                    discover(v);
                end
                else if (colour[v] == COLOR_GRAY)
                begin
                    tbl_class[e] = ECLASS_BACK;
                    back_total = back_total + 6'd1;
                end
                else if (disc_at[u] < disc_at[v])
                    tbl_class[e] = ECLASS_FORWARD;
                else if (disc_at[u] > disc_at[v])
                    tbl_class[e] = ECLASS_CROSS;
            end
        end
    endfunction

    // Update the table copy for a load or clear; for a run, queue its records
    function automatic void predict_records(in_item_t it);
        int n;
        int total;
        int k;
        out_item_t rec;
        n = (nodes_cfg > NODE_LIMIT) ? NODE_LIMIT : int'(nodes_cfg);
        if (it.func == FUNC_LOAD)
        begin
            if (it.src < n && it.dst < n && tbl_fill < TABLE_DEPTH)
            begin
                tbl_src[tbl_fill] = it.src;
                tbl_dst[tbl_fill] = it.dst;
                tbl_fill++;
            end
            return;
        end
        if (it.func == FUNC_CLEAR)
        begin
            tbl_fill = 0;
            return;
        end
        if (it.func != FUNC_RUN)
            return;
        for (int i = 0; i < TABLE_DEPTH; i++)
            tbl_class[i] = ECLASS_NONE;
        for (int i = 0; i < NODE_LIMIT; i++)
        begin
            colour[i] = COLOR_WHITE;
            parent_of[i] = '0;
            has_parent[i] = 1'b0;
        end
        stk_depth = 0;
        tick = '0;
        back_total = '0;
        depth_first(n);
        total = n + tbl_fill;
        k = 0;
        for (int i = 0; i < n; i++)
        begin
            rec = '0;
            rec.kind = KIND_NODE;
            rec.index = i[4:0];
            rec.discovery = disc_at[i];
            rec.finish = fin_at[i];
            rec.predecessor = has_parent[i] ? parent_of[i] : 4'd0;
            rec.has_predecessor = has_parent[i];
            rec.cycle_count = back_total;
            rec.last = (k + 1 == total);
            pending_records.insert(pending_records.size(), rec);
            k++;
        end
        for (int i = 0; i < tbl_fill; i++)
        begin
            rec = '0;
            rec.kind = KIND_EDGE;
            rec.index = i[4:0];
            rec.edge_type = tbl_class[i];
            rec.cycle_count = back_total;
            rec.last = (k + 1 == total);
            pending_records.insert(pending_records.size(), rec);
            k++;
        end
    endfunction

    // Check every accepted record against the oldest one predicted
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            records_seen++;
            if (pending_records.size() == 0)
            begin
                $error("record with nothing predicted: %p", out_item);
                failures++;
            end
            else
            begin
                want = pending_records.pop_front();
                if (out_item.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, out_item.kind);
                    failures++;
                end
                if (out_item.index !== want.index)
                begin
                    $error("index: expected %0d, got %0d", want.index, out_item.index);
                    failures++;
                end
                if (out_item.discovery !== want.discovery)
                begin
                    $error("discovery: expected %0d, got %0d",
                           want.discovery, out_item.discovery);
                    failures++;
                end
                if (out_item.finish !== want.finish)
                begin
                    $error("finish: expected %0d, got %0d", want.finish, out_item.finish);
                    failures++;
                end
                if (out_item.predecessor !== want.predecessor)
                begin
                    $error("predecessor: expected %0d, got %0d",
                           want.predecessor, out_item.predecessor);
                    failures++;
                end
                if (out_item.has_predecessor !== want.has_predecessor)
                begin
                    $error("has_predecessor: expected %0d, got %0d",
                           want.has_predecessor, out_item.has_predecessor);
                    failures++;
                end
                if (out_item.edge_type !== want.edge_type)
                begin
                    $error("edge_type: expected %0d, got %0d",
                           want.edge_type, out_item.edge_type);
                    failures++;
                end
                if (out_item.cycle_count !== want.cycle_count)
                begin
                    $error("cycle_count: expected %0d, got %0d",
                           want.cycle_count, out_item.cycle_count);
                    failures++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    failures++;
                end
            end
        end
    end

    // Receiver back-pressure: cycle through calm, light and heavy stall phases
    initial
    begin
        int phase_cycles;
        int stall_pct;
        out_stall = 1'b1;
        forever
        begin
            phase_cycles = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 25;
                default: stall_pct = 75;
            endcase
            repeat (phase_cycles)
            begin
                @(negedge clk);
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Hand one item to the block; drop in_valid for a random gap whenever a burst runs out
    task automatic send_item(input logic [1:0] func, input logic [3:0] src,
                             input logic [3:0] dst);
        in_item_t it;
        it.func = func;
        it.src = src;
        it.dst = dst;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
            burst_left = $urandom_range(1, 10);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
        predict_records(it);
        if (func == FUNC_RUN)
            runs_sent++;
        if (func == FUNC_LOAD)
            loads_sent++;
        burst_left--;
    endtask

    // Drop valid and wait for every predicted record, then let the block settle
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write node_count; only ever called with the block idle
    task automatic set_nodes(input logic [4:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        nodes_cfg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Every edge class, a duplicate, self-loops and the unused func code on the
    // full sixteen-node graph, then dropped loads and a clear on eight nodes
    task automatic test_edge_classes;
        set_nodes(5'd16);
        send_item(FUNC_LOAD, 4'd0, 4'd1);
        send_item(FUNC_LOAD, 4'd1, 4'd2);
        send_item(FUNC_LOAD, 4'd2, 4'd0);
        send_item(FUNC_LOAD, 4'd0, 4'd2);
        send_item(FUNC_LOAD, 4'd3, 4'd1);
        send_item(FUNC_LOAD, 4'd3, 4'd3);
        send_item(FUNC_LOAD, 4'd0, 4'd1);
        send_item(FUNC_LOAD, 4'd2, 4'd0);
        send_item(FUNC_LOAD, 4'd15, 4'd15);
        send_item(FUNC_LOAD, 4'd15, 4'd0);
        send_item(FUNC_LOAD, 4'd12, 4'd13);
        send_item(2'(FUNC_UNUSED), 4'd15, 4'd15);
        send_item(FUNC_RUN, 4'd0, 4'd0);
        // Shrink the graph: node 8 and above become stale, 9->1 and 1->9 are dropped
        set_nodes(5'd8);
        send_item(FUNC_LOAD, 4'd9, 4'd1);
        send_item(FUNC_LOAD, 4'd1, 4'd9);
        send_item(FUNC_LOAD, 4'd7, 4'd6);
        send_item(FUNC_RUN, 4'd15, 4'd15);
        send_item(FUNC_CLEAR, 4'd0, 4'd0);
        send_item(FUNC_RUN, 4'd0, 4'd0);
    endtask

    // No nodes: loads drop and a run searches nothing; then runs over a stale edge with zero and one node
    task automatic test_empty_graph;
        set_nodes(5'd0);
        send_item(FUNC_LOAD, 4'd0, 4'd0);
        send_item(FUNC_RUN, 4'd0, 4'd0);
        set_nodes(5'd16);
        send_item(FUNC_LOAD, 4'd5, 4'd6);
        set_nodes(5'd0);
        send_item(FUNC_RUN, 4'd0, 4'd0);
        set_nodes(5'd1);
        send_item(FUNC_RUN, 4'd0, 4'd0);
        send_item(FUNC_CLEAR, 4'd0, 4'd0);
    endtask

    // Overfill the table, then run with a count above the node limit
    task automatic test_full_table;
        set_nodes(5'd31);
        send_item(FUNC_CLEAR, 4'd0, 4'd0);
        for (int i = 0; i < TABLE_DEPTH + 3; i++)
            send_item(FUNC_LOAD, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        send_item(FUNC_RUN, 4'd0, 4'd0);
        send_item(FUNC_CLEAR, 4'd0, 4'd0);
    endtask

    // Random graphs: mostly in-range loads, with a random run at least once every fifteen items
    task automatic test_random_graphs;
        logic [4:0] choices [6] = '{5'd1, 5'd16, 5'd5, 5'd31, 5'd11, 5'd16};
        int n;
        int roll;
        int since_run;
        since_run = 0;
        for (int item = 0; item < 96; item++)
        begin
            if (item % 27 == 0)
                set_nodes(choices[(item / 27) % 6]);
            n = (nodes_cfg > NODE_LIMIT) ? NODE_LIMIT : int'(nodes_cfg);
            roll = $urandom_range(0, 99);
            if (since_run >= 14 || roll < 10)
            begin
                send_item(FUNC_RUN, 4'($urandom), 4'($urandom));
                since_run = 0;
            end
            else if (roll < 15)
            begin
                send_item(FUNC_CLEAR, 4'($urandom), 4'($urandom));
                since_run++;
            end
            else if (roll < 18)
            begin
                send_item(2'(FUNC_UNUSED), 4'($urandom), 4'($urandom));
                since_run++;
            end
            else if (roll < 26)
            begin
                send_item(FUNC_LOAD, 4'($urandom), 4'($urandom));
                since_run++;
            end
            else
            begin
                send_item(FUNC_LOAD, 4'($urandom_range(0, n - 1)),
                          4'($urandom_range(0, n - 1)));
                since_run++;
            end
        end
        send_item(FUNC_RUN, 4'd0, 4'd0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        failures = 0;
        records_seen = 0;
        runs_sent = 0;
        loads_sent = 0;
        burst_left = 0;
        tbl_fill = 0;
        stk_depth = 0;
        tick = '0;
        back_total = '0;
        nodes_cfg = 5'd16;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_src[i] = '0;
            tbl_dst[i] = '0;
            tbl_class[i] = ECLASS_NONE;
        end
        for (int i = 0; i < NODE_LIMIT; i++)
        begin
            colour[i] = COLOR_WHITE;
            disc_at[i] = '0;
            fin_at[i] = '0;
            parent_of[i] = '0;
            has_parent[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_classes();
        test_empty_graph();
        test_full_table();
        test_random_graphs();
        drain();

        $display("Covered %0d runs and %0d edge loads, %0d records checked,",
                 runs_sent, loads_sent, records_seen);
        $display("node counts from zero to above the node limit, under random stalls.");
        if (failures == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### dfs_edge_classifier.f
+incdir+hdl
hdl/dfs_pkg.sv
hdl/dfs_ram.sv
hdl/dfs_ctrl.sv
hdl/dfs_datapath.sv
hdl/dfs_edge_classifier.sv
dv/tb_dfs_edge_classifier.sv
